// ===== rtl/lfrb_pkg.sv =====
`timescale 1ns / 1ps

package lfrb_pkg;

  // Payload widths
  localparam int ACTION_W = 2;
  localparam int BYTE_W   = 8;
  localparam int LIMIT_W  = 7;
  localparam int FILL_W   = 6;

  // Action codes
  localparam logic [ACTION_W-1:0] ACT_RECEIVE = 2'd0;
  localparam logic [ACTION_W-1:0] ACT_TAKE    = 2'd1;
  localparam logic [ACTION_W-1:0] ACT_CLEAR   = 2'd2;

  // Special characters
  localparam logic [BYTE_W-1:0] CH_LF  = 8'h0A;
  localparam logic [BYTE_W-1:0] CH_CR  = 8'h0D;
  localparam logic [BYTE_W-1:0] CH_NUL = 8'h00;

  // Datapath operations
  typedef logic [3:0] dp_op_t;
  localparam dp_op_t OP_NOP      = 4'd0;
  localparam dp_op_t OP_LATCH    = 4'd1;  // capture input, base <= head, clear counters
  localparam dp_op_t OP_CLEAR    = 4'd2;  // empty the store, drop the flag
  localparam dp_op_t OP_WR_ZERO0 = 4'd3;  // zero byte at logical BUF_SIZE-2
  localparam dp_op_t OP_WR_ZERO1 = 4'd4;  // zero byte at logical BUF_SIZE-1, drop lower half
  localparam dp_op_t OP_APPEND   = 4'd5;  // store the received byte
  localparam dp_op_t OP_SCAN_RD  = 4'd6;  // read base+cnt
  localparam dp_op_t OP_SCAN_ADV = 4'd7;  // count one frame byte
  localparam dp_op_t OP_COMMIT   = 4'd8;  // consume cnt bytes
  localparam dp_op_t OP_EMIT_RD  = 4'd9;  // read base+idx
  localparam dp_op_t OP_IDX_ADV  = 4'd10; // next emitted byte

  typedef struct packed {
    dp_op_t op;
    logic   out_load;    // load the result register
    logic   out_status;  // load a status result instead of a frame byte
  } dp_cmd_t;

  typedef struct packed {
    logic [ACTION_W-1:0] action;
    logic                limit_small;
    logic                is_full;
    logic                scan_go;
    logic                byte_zero;
    logic                byte_eol;
    logic                cnt_zero;
    logic                emit_last;
    logic                out_free;
  } dp_status_t;

endpackage

// ===== rtl/lfrb_if.sv =====
`timescale 1ns / 1ps

// Request channel
interface lfrb_in_if import lfrb_pkg::*; ();
  logic                valid;
  logic                ready;
  logic [ACTION_W-1:0] action;
  logic [BYTE_W-1:0]   rx_byte;
  logic [LIMIT_W-1:0]  copy_limit;

  modport source (output valid, output action, output rx_byte, output copy_limit,
                  input ready);
  modport sink   (input valid, input action, input rx_byte, input copy_limit,
                  output ready);
endinterface

// Result channel
interface lfrb_out_if import lfrb_pkg::*; ();
  logic              valid;
  logic              ready;
  logic [BYTE_W-1:0] out_byte;
  logic              byte_valid;
  logic              last;
  logic              frame_ready;
  logic [FILL_W-1:0] fill_count;

  modport source (output valid, output out_byte, output byte_valid, output last,
                  output frame_ready, output fill_count, input ready);
  modport sink   (input valid, input out_byte, input byte_valid, input last,
                  input frame_ready, input fill_count, output ready);
endinterface

// ===== rtl/lfrb_datapath.sv =====
`timescale 1ns / 1ps

module lfrb_datapath import lfrb_pkg::*; #(
  parameter int BUF_SIZE = 64
) (
  input  logic                clk,
  input  logic                rst,
  input  dp_cmd_t             cmd,
  output dp_status_t          sts,
  input  logic [ACTION_W-1:0] in_action,
  input  logic [BYTE_W-1:0]   in_rx_byte,
  input  logic [LIMIT_W-1:0]  in_copy_limit,
  lfrb_out_if.source          out_ch
);

  localparam int AW = $clog2(BUF_SIZE);
  localparam int SW = AW + 1;
  localparam logic [AW-1:0] OFF_Z0 = AW'(BUF_SIZE - 2);
  localparam logic [AW-1:0] OFF_Z1 = AW'(BUF_SIZE - 1);
  localparam logic [AW-1:0] HALF   = AW'(BUF_SIZE / 2);

  // Circular address: one add and one compare-subtract
  function automatic logic [AW-1:0] wrap_add(input logic [AW-1:0] a,
                                             input logic [AW-1:0] b);
    logic [SW-1:0] s;
    s = {1'b0, a} + {1'b0, b};
    if (s >= SW'(BUF_SIZE)) s = s - SW'(BUF_SIZE);
    return s[AW-1:0];
  endfunction

  function automatic logic is_eol(input logic [BYTE_W-1:0] b);
    return (b == CH_LF) || (b == CH_CR);
  endfunction

  // Buffer state
  logic [AW-1:0] head;
  logic [AW-1:0] fill;
  logic          flag;

  // Per-request working registers
  logic [AW-1:0]       base;
  logic [AW-1:0]       cnt;
  logic [AW-1:0]       idx;
  logic [ACTION_W-1:0] act_q;
  logic [BYTE_W-1:0]   byte_q;
  logic [LIMIT_W-1:0]  limit_q;

  // Byte store
  logic [BYTE_W-1:0] mem [BUF_SIZE];
  logic [BYTE_W-1:0] rdata;
  logic              wr_en;
  logic              rd_en;
  logic [AW-1:0]     waddr;
  logic [AW-1:0]     raddr;
  logic [BYTE_W-1:0] wdata;

  // Result register
  logic              out_valid;
  logic [BYTE_W-1:0] out_byte;
  logic              out_bvalid;
  logic              out_last;
  logic              out_flag;
  logic [FILL_W-1:0] out_fill;

  // Store address and data select
  always_comb begin
    wr_en = 1'b0;
    waddr = head;
    wdata = byte_q;
    raddr = wrap_add(base, cnt);
    unique case (cmd.op)
      OP_WR_ZERO0: begin
        wr_en = 1'b1;
        waddr = wrap_add(head, OFF_Z0);
        wdata = CH_NUL;
      end
      OP_WR_ZERO1: begin
        wr_en = 1'b1;
        waddr = wrap_add(head, OFF_Z1);
        wdata = CH_NUL;
      end
      OP_APPEND: begin
        wr_en = 1'b1;
        waddr = wrap_add(head, fill);
      end
      OP_EMIT_RD: raddr = wrap_add(base, idx);
      default: ;
    endcase
  end

  assign rd_en = (cmd.op == OP_SCAN_RD) || (cmd.op == OP_EMIT_RD);

  always_ff @(posedge clk) begin
    if (wr_en) mem[waddr] <= wdata;
    if (rd_en) rdata <= mem[raddr];
  end

  // Head, fill and flag
  always_ff @(posedge clk) begin
    if (rst) begin
      head <= '0;
      fill <= '0;
      flag <= 1'b0;
    end else begin
      unique case (cmd.op)
        OP_CLEAR: begin
          fill <= '0;
          flag <= 1'b0;
        end
        OP_WR_ZERO1: begin
          head <= wrap_add(head, HALF);
          fill <= HALF;
        end
        OP_APPEND: begin
          fill <= fill + AW'(1);
          if (is_eol(byte_q)) flag <= 1'b1;
        end
        OP_COMMIT: begin
          head <= wrap_add(head, cnt);
          fill <= fill - cnt;
          if (cnt == fill) flag <= 1'b0;
        end
        default: ;
      endcase
    end
  end

  // Request capture and walk counters
  always_ff @(posedge clk) begin
    unique case (cmd.op)
      OP_LATCH: begin
        act_q   <= in_action;
        byte_q  <= in_rx_byte;
        limit_q <= in_copy_limit;
        base    <= head;
        cnt     <= '0;
        idx     <= '0;
      end
      OP_SCAN_ADV: cnt <= cnt + AW'(1);
      OP_IDX_ADV:  idx <= idx + AW'(1);
      default: ;
    endcase
  end

  // Result register: freed by a transfer, refilled by a load
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (cmd.out_load) begin
      out_valid <= 1'b1;
    end else if (out_ch.ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.out_load) begin
      out_byte   <= cmd.out_status ? CH_NUL : rdata;
      out_bvalid <= !cmd.out_status;
      out_last   <= cmd.out_status || sts.emit_last;
      out_flag   <= flag;
      out_fill   <= FILL_W'(fill);
    end
  end

  assign out_ch.valid       = out_valid;
  assign out_ch.out_byte    = out_byte;
  assign out_ch.byte_valid  = out_bvalid;
  assign out_ch.last        = out_last;
  assign out_ch.frame_ready = out_flag;
  assign out_ch.fill_count  = out_fill;

  // Status to the controller
  always_comb begin
    sts.action      = act_q;
    sts.limit_small = limit_q < LIMIT_W'(2);
    sts.is_full     = fill >= OFF_Z0;
    sts.scan_go     = ((LIMIT_W'(cnt) + LIMIT_W'(1)) < limit_q) && (cnt < fill);
    sts.byte_zero   = rdata == CH_NUL;
    sts.byte_eol    = is_eol(rdata);
    sts.cnt_zero    = cnt == '0;
    sts.emit_last   = (SW'(idx) + SW'(1)) == SW'(cnt);
    sts.out_free    = !out_valid || out_ch.ready;
  end

endmodule

// ===== rtl/lfrb_ctrl.sv =====
`timescale 1ns / 1ps

module lfrb_ctrl import lfrb_pkg::*; (
  input  logic       clk,
  input  logic       rst,
  input  logic       in_valid,
  output logic       in_ready,
  input  dp_status_t sts,
  output dp_cmd_t    cmd
);

  localparam logic [3:0] S_IDLE    = 4'd0;
  localparam logic [3:0] S_DECODE  = 4'd1;
  localparam logic [3:0] S_RX_Z0   = 4'd2;
  localparam logic [3:0] S_RX_Z1   = 4'd3;
  localparam logic [3:0] S_RX_APP  = 4'd4;
  localparam logic [3:0] S_STATUS  = 4'd5;
  localparam logic [3:0] S_SC_REQ  = 4'd6;
  localparam logic [3:0] S_SC_CHK  = 4'd7;
  localparam logic [3:0] S_COMMIT  = 4'd8;
  localparam logic [3:0] S_EM_REQ  = 4'd9;
  localparam logic [3:0] S_EM_OUT  = 4'd10;

  logic [3:0] state;
  logic [3:0] state_next;

  assign in_ready = state == S_IDLE;

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
    end else begin
      state <= state_next;
    end
  end

  // Sequencing
  always_comb begin
    state_next     = state;
    cmd.op         = OP_NOP;
    cmd.out_load   = 1'b0;
    cmd.out_status = 1'b0;
    unique case (state)
      S_IDLE: begin
        if (in_valid) begin
          cmd.op     = OP_LATCH;
          state_next = S_DECODE;
        end
      end
      S_DECODE: begin
        priority if (sts.action == ACT_RECEIVE) begin
          state_next = sts.is_full ? S_RX_Z0 : S_RX_APP;
        end else if (sts.action == ACT_TAKE) begin
          state_next = sts.limit_small ? S_STATUS : S_SC_REQ;
        end else if (sts.action == ACT_CLEAR) begin
          cmd.op     = OP_CLEAR;
          state_next = S_STATUS;
        end else begin
          state_next = S_STATUS;
        end
      end
      S_RX_Z0: begin
        cmd.op     = OP_WR_ZERO0;
        state_next = S_RX_Z1;
      end
      S_RX_Z1: begin
        cmd.op     = OP_WR_ZERO1;
        state_next = S_RX_APP;
      end
      S_RX_APP: begin
        cmd.op     = OP_APPEND;
        state_next = S_STATUS;
      end
      S_STATUS: begin
        if (sts.out_free) begin
          cmd.out_load   = 1'b1;
          cmd.out_status = 1'b1;
          state_next     = S_IDLE;
        end
      end
      // Find the frame length
      S_SC_REQ: begin
        if (sts.scan_go) begin
          cmd.op     = OP_SCAN_RD;
          state_next = S_SC_CHK;
        end else begin
          state_next = S_COMMIT;
        end
      end
      S_SC_CHK: begin
        if (sts.byte_zero) begin
          state_next = S_COMMIT;
        end else begin
          cmd.op     = OP_SCAN_ADV;
          state_next = sts.byte_eol ? S_COMMIT : S_SC_REQ;
        end
      end
      S_COMMIT: begin
        cmd.op     = OP_COMMIT;
        state_next = sts.cnt_zero ? S_STATUS : S_EM_REQ;
      end
      // Replay the frame bytes
      S_EM_REQ: begin
        cmd.op     = OP_EMIT_RD;
        state_next = S_EM_OUT;
      end
      S_EM_OUT: begin
        if (sts.out_free) begin
          cmd.op       = OP_IDX_ADV;
          cmd.out_load = 1'b1;
          state_next   = sts.emit_last ? S_IDLE : S_EM_REQ;
        end
      end
      default: state_next = S_IDLE;
    endcase
  end

endmodule

// ===== rtl/line_frame_receive_buffer_unit.sv =====
`timescale 1ns / 1ps
// Receive byte: append, then load the status result; a full store folds its upper half
// down first. Clear, unused action and small limit load only the status result.
// One request is worked on at a time. Take frame: scan to a line end, NUL, limit or fill,
// commit, then emit bytes in turn (one store read port), or the status result if none.
// Results wait in an output register; a new request is taken once the last one is loaded.
// Reset is synchronous: fill and flag clear at once, store contents stay undefined.

module line_frame_receive_buffer_unit import lfrb_pkg::*; #(
  parameter int BUF_SIZE = 64
) (
  input  logic       clk,
  input  logic       rst,
  lfrb_in_if.sink    in_ch,
  lfrb_out_if.source out_ch
);

  dp_cmd_t    cmd;
  dp_status_t sts;

  lfrb_ctrl u_ctrl (
    .clk      (clk),
    .rst      (rst),
    .in_valid (in_ch.valid),
    .in_ready (in_ch.ready),
    .sts      (sts),
    .cmd      (cmd)
  );

  lfrb_datapath #(
    .BUF_SIZE (BUF_SIZE)
  ) u_datapath (
    .clk           (clk),
    .rst           (rst),
    .cmd           (cmd),
    .sts           (sts),
    .in_action     (in_ch.action),
    .in_rx_byte    (in_ch.rx_byte),
    .in_copy_limit (in_ch.copy_limit),
    .out_ch        (out_ch)
  );

`ifndef SYNTHESIS
  // Busy in the cycle after a request transfer
  a_busy_after_accept: assert property (@(posedge clk) disable iff (rst)
    (in_ch.valid && in_ch.ready) |=> !in_ch.ready)
    else $error("request taken while previous one in progress");

  // Fold keeps the fill at or below BUF_SIZE-2
  a_fill_bound: assert property (@(posedge clk) disable iff (rst)
    out_ch.valid |-> (out_ch.fill_count <= FILL_W'(BUF_SIZE - 2)))
    else $error("fill count beyond store capacity");

  // A status result is always the only result of its request
  a_status_last: assert property (@(posedge clk) disable iff (rst)
    (out_ch.valid && !out_ch.byte_valid) |-> out_ch.last)
    else $error("status result not marked last");

  // Result and command loads never collide with a held result
  a_no_overwrite: assert property (@(posedge clk) disable iff (rst)
    (out_ch.valid && !out_ch.ready) |-> !cmd.out_load)
    else $error("result register overwritten before transfer");
`endif

endmodule
